[rtl/core/mfv_pkg.sv]
// ----------------------------------------------------------------------------
// mfv_pkg
// Shared constants, types and sequencer codes of the most frequent value
// finder.
// ----------------------------------------------------------------------------
package mfv_pkg;

    // Store depth and derived widths
    localparam int MAX_ITEMS = 1024;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int VAL_W     = 32;
    localparam int COUNT_W   = 11;   // width of the mode_count output field

    typedef logic        [ADDR_W-1:0] t_addr;
    typedef logic        [CNT_W-1:0]  t_cnt;
    typedef logic signed [VAL_W-1:0]  t_val;
    typedef logic        [COUNT_W-1:0] t_count_out;

    localparam t_cnt CNT_MAX = CNT_W'(MAX_ITEMS);
    localparam t_cnt CNT_ONE = CNT_W'(1);

    // Sequencer states
    typedef enum logic [2:0] {
        S_LOAD,
        S_CAND,
        S_LATCH,
        S_SCAN,
        S_EVAL,
        S_OUT
    } t_state;

    // Sequencer to tally unit controls
    typedef struct packed {
        logic best_clr;   // start a new set: forget the best run
        logic run_clr;    // start counting a new candidate
        logic cand_load;  // capture read data as the candidate
        logic cmp_en;     // read data is valid, compare against candidate
        logic eval;       // candidate count done, update best
    } t_tally_ctl;

endpackage

[rtl/core/mfv_in_if.sv]
// ----------------------------------------------------------------------------
// mfv_in_if
// Input item channel: one sample value and its last-item flag.
// ----------------------------------------------------------------------------
interface mfv_in_if;
    import mfv_pkg::*;

    logic valid;
    logic ready;
    t_val sample_value;
    logic last_item;

    modport source (output valid, output sample_value, output last_item, input ready);
    modport sink   (input valid, input sample_value, input last_item, output ready);

endinterface

[rtl/core/mfv_out_if.sv]
// ----------------------------------------------------------------------------
// mfv_out_if
// Result item channel: mode value, its count and the overflow flag.
// ----------------------------------------------------------------------------
interface mfv_out_if;
    import mfv_pkg::*;

    logic       valid;
    logic       ready;
    t_val       mode_value;
    t_count_out mode_count;
    logic       overflow;

    modport source (output valid, output mode_value, output mode_count, output overflow,
                    input ready);
    modport sink   (input valid, input mode_value, input mode_count, input overflow,
                    output ready);

endinterface

[rtl/core/mfv_store.sv]
// ----------------------------------------------------------------------------
// mfv_store
// Sample store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mfv_store (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  mfv_pkg::t_addr i_wr_addr,
    input  mfv_pkg::t_val  i_wr_data,
    input  mfv_pkg::t_addr i_rd_addr,
    output mfv_pkg::t_val  o_rd_data
);
    import mfv_pkg::*;

    t_val r_mem [MAX_ITEMS];
    t_val r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/mfv_tally.sv]
// ----------------------------------------------------------------------------
// mfv_tally
// Shared compare unit: counts how often the candidate occurs in the store
// and keeps the best (longest, then smallest) candidate seen so far.
// ----------------------------------------------------------------------------
module mfv_tally (
    input  logic               i_clk,
    input  mfv_pkg::t_tally_ctl i_ctl,
    input  mfv_pkg::t_val       i_rd_data,
    output mfv_pkg::t_val       o_best_val,
    output mfv_pkg::t_cnt       o_best_cnt
);
    import mfv_pkg::*;

    t_val r_cand;
    t_cnt r_run;
    t_val r_best_val;
    t_cnt r_best_cnt;

    logic w_eq;
    logic w_better;

    // Equality against candidate during the sweep
    assign w_eq = (i_rd_data == r_cand);

    // Longer run wins; equal run goes to the smaller value
    assign w_better = (r_run > r_best_cnt) ||
                      ((r_run == r_best_cnt) && (r_cand < r_best_val));

    // Candidate and run counter
    always_ff @(posedge i_clk) begin
        if (i_ctl.cand_load) begin
            r_cand <= i_rd_data;
        end
        if (i_ctl.run_clr) begin
            r_run <= '0;
        end else if (i_ctl.cmp_en && w_eq) begin
            r_run <= r_run + CNT_ONE;
        end
    end

    // Best result so far
    always_ff @(posedge i_clk) begin
        if (i_ctl.best_clr) begin
            r_best_cnt <= '0;
        end else if (i_ctl.eval && w_better) begin
            r_best_cnt <= r_run;
            r_best_val <= r_cand;
        end
    end

    assign o_best_val = r_best_val;
    assign o_best_cnt = r_best_cnt;

endmodule

[rtl/core/mfv_seq.sv]
// ----------------------------------------------------------------------------
// mfv_seq
// Sequencer: loads the set, then for every stored entry sweeps the store
// once to count that value, and finally presents the result.
// ----------------------------------------------------------------------------
module mfv_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_last,
    output logic                o_in_ready,
    output logic                o_wr_en,
    output mfv_pkg::t_addr      o_wr_addr,
    output mfv_pkg::t_addr      o_rd_addr,
    output mfv_pkg::t_tally_ctl o_ctl,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_overflow
);
    import mfv_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cnt   r_cnt;    // entries stored for the current set
    logic   r_ovf;    // an item was dropped
    t_addr  r_i;      // candidate index
    t_cnt   r_j;      // sweep read index
    logic   r_pend;   // read data of the sweep is valid this cycle

    logic w_in_fire;
    logic w_room;
    logic w_last_cand;
    logic w_issue;

    assign w_in_fire   = i_in_valid && (r_state == S_LOAD);
    assign w_room      = (r_cnt < CNT_MAX);
    assign w_last_cand = (CNT_W'(r_i) == (r_cnt - CNT_ONE));
    assign w_issue     = (r_j < r_cnt);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD:  if (w_in_fire && i_last) n_state = S_CAND;
            S_CAND:  n_state = S_LATCH;
            S_LATCH: n_state = S_SCAN;
            S_SCAN:  if (!w_issue && !r_pend) n_state = S_EVAL;
            S_EVAL:  n_state = w_last_cand ? S_OUT : S_CAND;
            S_OUT:   if (i_out_ready) n_state = S_LOAD;
            default: n_state = S_LOAD;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_wr_en     = 1'b0;
        o_rd_addr   = '0;
        o_ctl       = '0;
        o_out_valid = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_in_ready     = 1'b1;
                o_wr_en        = w_in_fire && w_room;
                o_ctl.best_clr = w_in_fire && i_last;
            end
            S_CAND: begin
                o_rd_addr     = r_i;
                o_ctl.run_clr = 1'b1;
            end
            S_LATCH: begin
                o_ctl.cand_load = 1'b1;
            end
            S_SCAN: begin
                o_rd_addr    = r_j[ADDR_W-1:0];
                o_ctl.cmp_en = r_pend;
            end
            S_EVAL: begin
                o_ctl.eval = 1'b1;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign o_wr_addr  = r_cnt[ADDR_W-1:0];
    assign o_overflow = r_ovf;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Fill count and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (r_state == S_OUT && i_out_ready) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (w_in_fire) begin
            if (w_room) begin
                r_cnt <= r_cnt + CNT_ONE;
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    // Candidate and sweep indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i    <= '0;
            r_j    <= '0;
            r_pend <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    r_i    <= '0;
                    r_pend <= 1'b0;
                end
                S_LATCH: begin
                    // entry 0 was already addressed in this cycle
                    r_j    <= CNT_ONE;
                    r_pend <= 1'b1;
                end
                S_SCAN: begin
                    if (w_issue) begin
                        r_j    <= r_j + CNT_ONE;
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                end
                S_EVAL: begin
                    if (!w_last_cand) begin
                        r_i <= r_i + ADDR_W'(1);
                    end
                end
                default: begin
                    r_pend <= r_pend;
                end
            endcase
        end
    end

    // Checks
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("fill count beyond store depth");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_cnt == CNT_MAX))
        else $error("overflow flagged with room left");

    a_out_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && i_out_ready) |=> (r_state == S_LOAD && r_cnt == '0 && !r_ovf))
        else $error("set not cleared after result");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_j <= r_cnt && r_cnt != '0))
        else $error("sweep index out of range");

endmodule

[rtl/core/most_frequent_value_finder_unit.sv]
// ----------------------------------------------------------------------------
// most_frequent_value_finder_unit
// Finds the most frequent value of a set of signed samples (smallest value
// on a tie) and reports it with its count and an overflow flag.
//
//   Channel   Dir  Payload                                  Item
//   i_in      in   sample_value[31:0] signed, last_item     one sample
//   o_out     out  mode_value[31:0] signed, mode_count[10:0], overflow
//                                                           one result per set
//
// Samples load at one per cycle. After the last item each of the n stored
// entries is counted by one sweep of the store's single read port before the
// result is presented. The input is not ready from the last item until the
// result is taken. Items beyond the store depth are dropped and flagged.
// Reset is synchronous; the store needs no clearing.
// ----------------------------------------------------------------------------
module most_frequent_value_finder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mfv_in_if.sink      i_in,
    mfv_out_if.source   o_out
);
    import mfv_pkg::*;

    t_tally_ctl w_ctl;
    logic       w_wr_en;
    t_addr      w_wr_addr;
    t_addr      w_rd_addr;
    t_val       w_rd_data;
    t_val       w_best_val;
    t_cnt       w_best_cnt;
    logic       w_in_ready;
    logic       w_out_valid;
    logic       w_overflow;

    // Sequencer
    mfv_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_last      (i_in.last_item),
        .o_in_ready  (w_in_ready),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_rd_addr   (w_rd_addr),
        .o_ctl       (w_ctl),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_overflow  (w_overflow)
    );

    // Sample store
    mfv_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_in.sample_value),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Compare and count unit
    mfv_tally u_tally (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_rd_data  (w_rd_data),
        .o_best_val (w_best_val),
        .o_best_cnt (w_best_cnt)
    );

    // Channel hookup; result fields hold steady while the result waits
    assign i_in.ready       = w_in_ready;
    assign o_out.valid      = w_out_valid;
    assign o_out.mode_value = w_best_val;
    assign o_out.mode_count = COUNT_W'(w_best_cnt);
    assign o_out.overflow   = w_overflow;

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for most_frequent_value_finder_unit. Sample sets are
// streamed through the input channel while a local predictor keeps its own
// copy of the store. Each closed set yields one expected mode, count and
// overflow flag, which is checked against the result channel in order.
// Both channels idle at random in three mixes; one long set fills the store
// and spills over.
// ----------------------------------------------------------------------------
module testbench;
    import mfv_pkg::*;

    // The watchdog limit must outlast a full store sweep, during which nothing is accepted
    localparam int   STALL_LIMIT = 4_000_000;
    localparam int   DRAIN_TAIL  = 64;
    localparam int   REPORT_MAX  = 10;
    localparam t_val VAL_MIN     = 32'sh8000_0000;
    localparam t_val VAL_MAX     = 32'sh7FFF_FFFF;

    typedef struct packed {
        t_val       mode_value;
        t_count_out mode_count;
        logic       overflow;
    } mode_result_t;

    logic i_clk;
    logic i_rst_n;

    mfv_in_if  in_ch ();
    mfv_out_if out_ch ();

    most_frequent_value_finder_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Predictor state: our own copy of the loaded set
    t_val         sample_store [MAX_ITEMS];
    int           samples_held;
    logic         set_dropped;
    mode_result_t pending_results [$];

    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int sets_checked;
    int mismatch_count;
    int stall_cycles;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Mode of the held set: longest run, smallest value on a tie
    function automatic mode_result_t predict_mode();
        mode_result_t r;
        int           best;
        int           run;
        best         = 0;
        r.mode_value = '0;
        for (int i = 0; i < samples_held; i++) begin
            run = 0;
            for (int j = 0; j < samples_held; j++) begin
                if (sample_store[j] == sample_store[i]) run++;
            end
            if (run > best || (run == best && sample_store[i] < r.mode_value)) begin
                best         = run;
                r.mode_value = sample_store[i];
            end
        end
        r.mode_count = COUNT_W'(best);
        r.overflow   = set_dropped;
        return r;
    endfunction

    // Track one accepted sample; a closing item queues its result
    function automatic void absorb_sample(input t_val value, input logic last);
        if (samples_held < MAX_ITEMS) begin
            sample_store[samples_held] = value;
            samples_held++;
        end else begin
            set_dropped = 1'b1;
        end
        if (last) begin
            pending_results.push_back(predict_mode());
            samples_held = 0;
            set_dropped  = 1'b0;
        end
    endfunction

    function automatic void report_mismatch(input string msg);
        if (mismatch_count < REPORT_MAX) $display("%0t mismatch: %s", $realtime, msg);
        mismatch_count++;
    endfunction

    // Send one sample, with random idle cycles ahead of it
    task automatic send_sample(input t_val value, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid        <= 1'b0;
            in_ch.sample_value <= $urandom;
            in_ch.last_item    <= 1'($urandom_range(1));
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.sample_value <= value;
        in_ch.last_item    <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
        absorb_sample(value, last);
    endtask

    task automatic send_set(input t_val vals [$]);
        foreach (vals[k]) send_sample(vals[k], k == vals.size() - 1);
    endtask

    // Hold the input quiet until every queued result is back
    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // --- tests --------------------------------------------------------------

    task automatic test_single_item_sets();
        send_set('{VAL_MIN});
        send_set('{VAL_MAX});
        send_set('{t_val'(0)});
        send_set('{t_val'(-1)});
    endtask

    task automatic test_tie_break();
        send_set('{t_val'(7), t_val'(7), t_val'(-3), t_val'(-3), VAL_MAX});
        send_set('{VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN});
        send_set('{t_val'(30), t_val'(10), t_val'(20)});
    endtask

    task automatic test_clear_winner();
        send_set('{t_val'(2), t_val'(9), t_val'(9), t_val'(2), t_val'(9), t_val'(-5)});
    endtask

    // Sender stops until the pipeline is empty, then resumes
    task automatic test_pause_between_sets();
        send_set('{t_val'($urandom), t_val'($urandom)});
        wait_for_results();
        send_set('{t_val'($urandom)});
    endtask

    // Random sets drawn from small pools so that values repeat
    task automatic test_random_sets(input int item_budget, input int send_pct,
                                    input int recv_pct);
        t_val pool [8];
        t_val set_vals [$];
        int   pool_size;
        int   set_size;
        int   start;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start         = items_sent;
        while (items_sent - start < item_budget) begin
            pool_size = $urandom_range(1, 6);
            for (int k = 0; k < pool_size; k++) begin
                case ($urandom_range(3))
                    0, 1: pool[k] = t_val'($urandom);
                    2:    pool[k] = t_val'(int'($urandom_range(16)) - 8);
                    default: begin
                        case ($urandom_range(3))
                            0:       pool[k] = VAL_MIN;
                            1:       pool[k] = VAL_MAX;
                            2:       pool[k] = t_val'(0);
                            default: pool[k] = t_val'(-1);
                        endcase
                    end
                endcase
            end
            set_size = ($urandom_range(99) < 85) ? $urandom_range(1, 12)
                                                  : $urandom_range(13, 48);
            set_vals.delete();
            for (int k = 0; k < set_size; k++) begin
                if ($urandom_range(9) == 0) set_vals.push_back(t_val'($urandom));
                else                        set_vals.push_back(pool[$urandom_range(pool_size - 1)]);
            end
            send_set(set_vals);
        end
    endtask

    // Fill the store with one value, then spill; the closing item is dropped
    task automatic test_store_overflow();
        for (int k = 0; k < MAX_ITEMS; k++) send_sample(t_val'(-7), 1'b0);
        for (int k = 0; k < 3; k++) send_sample(VAL_MAX, 1'b0);
        send_sample(VAL_MIN, 1'b1);
    endtask

    // --- result checker -----------------------------------------------------

    always @(posedge i_clk) begin : check_results
        mode_result_t exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result value %0d count %0d ovf %0b",
                    out_ch.mode_value, out_ch.mode_count, out_ch.overflow));
            end else begin
                exp_r = pending_results.pop_front();
                sets_checked++;
                if (out_ch.mode_value !== exp_r.mode_value ||
                    out_ch.mode_count !== exp_r.mode_count ||
                    out_ch.overflow   !== exp_r.overflow) begin
                    report_mismatch($sformatf(
                        "set %0d exp value %0d count %0d ovf %0b, got %0d %0d %0b",
                        sets_checked, exp_r.mode_value, exp_r.mode_count, exp_r.overflow,
                        out_ch.mode_value, out_ch.mode_count, out_ch.overflow));
                end
            end
        end
    end

    // Receiver back-pressure
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d idle cycles", stall_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // --- sequence -----------------------------------------------------------

    initial begin
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.sample_value <= '0;
        in_ch.last_item    <= 1'b0;
        samples_held   = 0;
        set_dropped    = 1'b0;
        items_sent     = 0;
        sets_checked   = 0;
        mismatch_count = 0;
        stall_cycles   = 0;
        send_idle_pct  = 33;
        recv_idle_pct  = 79;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_single_item_sets();
        test_tie_break();
        test_clear_winner();
        test_pause_between_sets();
        test_random_sets(155, 33, 79);
        test_random_sets(155, 79, 33);
        test_random_sets(155, 0, 0);
        test_store_overflow();

        wait_for_results();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        end
        if (mismatch_count > REPORT_MAX)
            $display("%0d further mismatches not shown", mismatch_count - REPORT_MAX);
        $display("Checked %0d sets from %0d samples: single values, ties, random pools,",
                 sets_checked, items_sent);
        $display("three idle mixes, a pause to empty and a full store with overflow.");
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/mfv_pkg.sv
rtl/core/mfv_in_if.sv
rtl/core/mfv_out_if.sv
rtl/core/mfv_store.sv
rtl/core/mfv_tally.sv
rtl/core/mfv_seq.sv
rtl/core/most_frequent_value_finder_unit.sv
bench/testbench.sv
